// ===== design/usbnrzi_pkg.sv =====
// ----------------------------------------------------------------------------
// USB NRZI serializer package
// Shared types and constants for the NRZI / bit-stuffing serializer.
// ----------------------------------------------------------------------------
package usbnrzi_pkg;

    // Configuration register indexes.
    localparam logic [3:0] CFG_SYNC_PATTERN = 4'd0;
    localparam logic [3:0] CFG_STUFF_LIMIT  = 4'd1;

    // Register reset values.
    localparam logic [15:0] SYNC_RESET  = 16'h999A;
    localparam logic [2:0]  STUFF_RESET = 3'd6;

    // Symbol counts.
    localparam logic [3:0] SYNC_SYMBOLS = 4'd8;
    localparam logic [3:0] LAST_SYMBOL  = 4'd15;

    // Two-bit line symbols (D-/D+).
    localparam logic [1:0] SYM_LEVEL1 = 2'b01;
    localparam logic [1:0] SYM_LEVEL0 = 2'b10;
    localparam logic [1:0] SYM_SE0    = 2'b00;

    // Input item: one packet byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // Result item: one packed word of 16 symbols.
    typedef struct packed {
        logic [31:0] tx_word;
        logic        last_word;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_PAD
    } state_t;

endpackage

// ===== design/usb_nrzi_bitstuff_serializer_unit.sv =====
// ----------------------------------------------------------------------------
// USB NRZI bit-stuffing serializer
// Encodes packet bytes into NRZI line symbols with bit stuffing and packs
// them, sixteen two-bit symbols at a time, into 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_ channel, least significant bit first; last_byte
//   closes the packet. Words leave on the m_ channel, oldest symbol in the
//   top bits. The first word of a packet starts with the eight SYNC symbols
//   from the sync_pattern register; the closing word is padded with SE0.
//   The cfg_ channel writes sync_pattern (index 0) and stuff_limit (index 1)
//   and is always ready; users make writes while the block is idle (unenforced).
// Timing:
//   The bit sequencer produces one symbol per cycle unless a finished word
//   waits for the output register. Each byte is accepted, then its eight
//   data bits and any stuffed bits are shifted; no byte is taken meanwhile.
//   After the last byte the pad sequencer shifts in one SE0 symbol per cycle
//   until the closing word is full, and issues it once the output is free.
// Reset and stall:
//   Reset clears the sequencer, the output register and the packet state and
//   restores the register defaults. Finished words sit in an output register;
//   when the receiver stalls, the block keeps working and waits only when the
//   next word completes while the previous one has not been taken.
// ----------------------------------------------------------------------------
module usb_nrzi_bitstuff_serializer_unit
    import usbnrzi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Byte input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    // Word output channel
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t      state_reg, state_next;
    logic [15:0] sync_reg;
    logic [2:0]  limit_reg;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        last_reg, last_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  count_reg, count_next;
    logic [2:0]  ones_reg, ones_next;
    logic        level_reg, level_next;
    logic        open_reg, open_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic        bits_active;
    logic        pad_active;
    logic        accept;
    logic        out_free;
    logic [2:0]  limit_eff;
    logic        do_stuff;
    logic        sym_level;
    logic [1:0]  sym;
    logic [31:0] shifted;
    logic        bits_step;
    logic        data_done;
    logic        pad_step;
    logic        pad_done;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    // Common handshake terms.
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // A stuff limit of zero behaves as one.
    assign limit_eff = (limit_reg == 3'd0) ? 3'd1 : limit_reg;

    // Next symbol of the bit sequencer: a stuffed bit or a zero toggles the level.
    assign do_stuff  = (ones_reg >= limit_eff);
    assign sym_level = (do_stuff || !byte_reg[0]) ? ~level_reg : level_reg;
    assign sym       = sym_level ? SYM_LEVEL1 : SYM_LEVEL0;
    assign shifted   = {word_reg[29:0], (pad_active ? SYM_SE0 : sym)};

    // A step that completes a word waits for the output register.
    assign bits_step = bits_active && ((count_reg != LAST_SYMBOL) || out_free);
    assign data_done = bits_step && !do_stuff && (bit_cnt_reg == 3'd7);
    assign pad_done  = (count_reg == 4'd0) || (count_reg == LAST_SYMBOL);
    assign pad_step  = pad_active && (!pad_done || out_free);

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS: begin
                if (data_done) begin
                    state_next = last_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (pad_step && pad_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready     = 1'b0;
        bits_active = 1'b0;
        pad_active  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_BITS: begin
                bits_active = 1'b1;
            end
            ST_PAD: begin
                pad_active = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath: byte shifter, symbol shifter and output register.
    always_comb begin
        byte_next    = byte_reg;
        bit_cnt_next = bit_cnt_reg;
        last_next    = last_reg;
        word_next    = word_reg;
        count_next   = count_reg;
        ones_next    = ones_reg;
        level_next   = level_reg;
        open_next    = open_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // The pending word is gone once its transfer completes.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Take a byte; the first byte of a packet loads the SYNC symbols.
        if (accept) begin
            byte_next    = s_data.data_byte;
            last_next    = s_data.last_byte;
            bit_cnt_next = 3'd0;
            if (!open_reg) begin
                word_next  = {16'd0, sync_reg};
                count_next = SYNC_SYMBOLS;
                ones_next  = 3'd0;
                level_next = 1'b0;
                open_next  = 1'b1;
            end
        end

        // One NRZI symbol per cycle, stuffed or data, unless a finished word waits for the output register.
        if (bits_step) begin
            level_next = sym_level;
            if (do_stuff || !byte_reg[0]) begin
                ones_next = 3'd0;
            end else if (ones_reg != 3'd7) begin
                ones_next = ones_reg + 3'd1;
            end
            if (!do_stuff) begin
                byte_next    = {1'b0, byte_reg[7:1]};
                bit_cnt_next = bit_cnt_reg + 3'd1;
            end
            if (count_reg == LAST_SYMBOL) begin
                m_valid_next          = 1'b1;
                m_data_next.tx_word   = shifted;
                m_data_next.last_word = 1'b0;
                word_next             = 32'd0;
                count_next            = 4'd0;
            end else begin
                word_next  = shifted;
                count_next = count_reg + 4'd1;
            end
        end

        // SE0 padding of the closing word, one symbol per cycle; the closing step waits for the output register.
        if (pad_step) begin
            if (pad_done) begin
                m_valid_next          = 1'b1;
                m_data_next.tx_word   = (count_reg == 4'd0) ? 32'd0 : shifted;
                m_data_next.last_word = 1'b1;
                word_next             = 32'd0;
                count_next            = 4'd0;
                open_next             = 1'b0;
            end else begin
                word_next  = shifted;
                count_next = count_reg + 4'd1;
            end
        end
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sync_reg    <= SYNC_RESET;
            limit_reg   <= STUFF_RESET;
            open_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= SYNC_SYMBOLS;
            ones_reg    <= 3'd0;
            level_reg   <= 1'b0;
            bit_cnt_reg <= 3'd0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            ones_reg    <= ones_next;
            level_reg   <= level_next;
            bit_cnt_reg <= bit_cnt_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SYNC_PATTERN: sync_reg  <= cfg_data;
                    CFG_STUFF_LIMIT:  limit_reg <= cfg_data[2:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the USB NRZI bit-stuffing serializer
// Drives packet bytes through the valid/ready input channel, predicts every
// output word with a bit-accurate encoder model kept inside the bench, and
// compares each word as it leaves. A directed table covers the corner cases
// first; random packets under several stuff limits, SYNC patterns and
// flow-control mixes follow, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import usbnrzi_pkg::*;

    localparam int WORD_SYMBOLS  = 16;
    localparam int DRAIN_CYCLES  = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 50;
    localparam int RANDOM_PHASES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        bit          is_cfg;
        logic [3:0]  idx;
        logic [15:0] val;
        in_item_t    item;
        int          typed_n;
        out_item_t   typed0;
        out_item_t   typed1;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [15:0] cfg_data;

    // Encoder state mirrored by the bench.
    logic [15:0] enc_sync;
    logic [2:0]  enc_limit;
    logic [31:0] enc_shift;
    int          enc_count;
    logic [2:0]  enc_ones;
    logic        enc_level;
    bit          enc_open;
    out_item_t   new_words[2];
    int          new_count;

    out_item_t   pending_words[$];
    dir_row_t    dir_rows[$];
    int          err_count;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;

    usb_nrzi_bitstuff_serializer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Encoder prediction
    // ------------------------------------------------------------------------

    // A new packet starts from the SYNC symbols with the line at level 0.
    function automatic void start_packet();
        enc_shift = {16'h0000, enc_sync};
        enc_count = int'(SYNC_SYMBOLS);
        enc_ones  = 3'd0;
        enc_level = 1'b0;
    endfunction

    // Shift the current line level in as one symbol; a full word goes out.
    function automatic void shift_level();
        enc_shift = {enc_shift[29:0], enc_level ? SYM_LEVEL1 : SYM_LEVEL0};
        enc_count++;
        if (enc_count >= WORD_SYMBOLS) begin
            new_words[new_count] = '{tx_word: enc_shift, last_word: 1'b0};
            new_count++;
            enc_shift = 32'h0;
            enc_count = 0;
        end
    endfunction

    // Encode one byte, collecting the words it completes in new_words.
    function automatic void encode_byte(input in_item_t it);
        logic [2:0]  lim;
        logic [31:0] closing;
        lim = (enc_limit == 3'd0) ? 3'd1 : enc_limit;
        new_count = 0;
        if (!enc_open) begin
            start_packet();
            enc_open = 1'b1;
        end
        for (int i = 0; i < 8; i++) begin
            // A pending stuff goes out before the next data bit only.
            if (enc_ones >= lim) begin
                enc_level = ~enc_level;
                enc_ones  = 3'd0;
                shift_level();
            end
            if (it.data_byte[i]) begin
                if (enc_ones < 3'd7) enc_ones = enc_ones + 3'd1;
            end else begin
                enc_level = ~enc_level;
                enc_ones  = 3'd0;
            end
            shift_level();
        end
        // The closing word is padded with SE0 symbols, or all SE0 if empty.
        if (it.last_byte) begin
            closing = (enc_count == 0) ? 32'h0 : enc_shift << (2 * (WORD_SYMBOLS - enc_count));
            new_words[new_count] = '{tx_word: closing, last_word: 1'b1};
            new_count++;
            start_packet();
            enc_open = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic dir_row_t row_byte(input logic [7:0] d, input bit last);
        dir_row_t r;
        r = '{is_cfg: 1'b0, idx: CFG_SYNC_PATTERN, val: 16'h0, item: '0,
              typed_n: 0, typed0: '0, typed1: '0};
        r.item.data_byte = d;
        r.item.last_byte = last;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input logic [3:0] idx, input logic [15:0] val);
        dir_row_t r;
        r = row_byte(8'h00, 1'b0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic dir_row_t row_typed(input logic [7:0] d, input logic [31:0] w0,
                                           input logic [31:0] w1);
        dir_row_t r;
        r = row_byte(d, 1'b1);
        r.typed_n = 2;
        r.typed0  = '{tx_word: w0, last_word: 1'b0};
        r.typed1  = '{tx_word: w1, last_word: 1'b1};
        return r;
    endfunction

    // Bias toward long runs of ones so that stuffing happens often.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25) return 8'hFF;
        if (r < 35) return 8'h00;
        if (r < 50) return ~(8'h01 << $urandom_range(7));
        return 8'($urandom);
    endfunction

    // Offer one byte and record the words it is due to produce.
    task automatic send_byte(input in_item_t it, input int typed_n,
                             input out_item_t typed0, input out_item_t typed1);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        encode_byte(it);
        if (typed_n > 0) begin
            pending_words.push_back(typed0);
            pending_words.push_back(typed1);
        end else begin
            for (int k = 0; k < new_count; k++) pending_words.push_back(new_words[k]);
        end
    endtask

    // Drop the input, let every expected word out, then let the pad logic settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SYNC_PATTERN) enc_sync = val;
        else if (idx == CFG_STUFF_LIMIT) enc_limit = val[2:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every word transfer is checked against the oldest expected word.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", m_data.tx_word, 32'h0);
            end else begin
                want = pending_words.pop_front();
                if (m_data.tx_word !== want.tx_word)
                    report_mismatch("tx_word", m_data.tx_word, want.tx_word);
                if (m_data.last_word !== want.last_word)
                    report_mismatch("last_word", 32'(m_data.last_word), 32'(want.last_word));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        dir_row_t r;
        int       sent;
        int       len;
        bit       last;
        in_item_t it;

        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SYNC_PATTERN;
        cfg_data    = 16'h0;
        err_count   = 0;
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_reqs   = 0;
        hold_seen   = 0;
        hold_left   = 0;
        enc_sync    = SYNC_RESET;
        enc_limit   = STUFF_RESET;
        enc_open    = 1'b0;
        start_packet();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed cases. The first two run from the reset defaults: eight
        // zeros fill the first word exactly and leave an all-SE0 closing word,
        // and eight ones stuff once before bit six.
        dir_rows.push_back(row_typed(8'h00, 32'h999A6666, 32'h00000000));
        dir_rows.push_back(row_typed(8'hFF, 32'h999AAAA5, 32'h40000000));
        // Runs of ones across bytes of one packet.
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_byte(8'hFF, 1'b1));
        // Run ending on the final data bit: nothing is stuffed after it.
        dir_rows.push_back(row_byte(8'hFC, 1'b1));
        // The same run mid-packet: the stuff carries into the next byte.
        dir_rows.push_back(row_byte(8'hFC, 1'b0));
        dir_rows.push_back(row_byte(8'h01, 1'b1));
        dir_rows.push_back(row_byte(8'h55, 1'b0));
        dir_rows.push_back(row_byte(8'hAA, 1'b1));
        dir_rows.push_back(row_byte(8'h80, 1'b0));
        dir_rows.push_back(row_byte(8'h01, 1'b1));
        // Tightest limit: a stuff after every one.
        dir_rows.push_back(row_cfg(CFG_STUFF_LIMIT, 16'd1));
        dir_rows.push_back(row_byte(8'hFF, 1'b1));
        // A zero limit behaves as a limit of one.
        dir_rows.push_back(row_cfg(CFG_STUFF_LIMIT, 16'd0));
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_byte(8'h7F, 1'b1));
        // Widest limit, where the run counter saturates.
        dir_rows.push_back(row_cfg(CFG_STUFF_LIMIT, 16'd7));
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_byte(8'hFF, 1'b1));
        // SYNC pattern extremes.
        dir_rows.push_back(row_cfg(CFG_SYNC_PATTERN, 16'h0000));
        dir_rows.push_back(row_byte(8'h00, 1'b1));
        dir_rows.push_back(row_cfg(CFG_SYNC_PATTERN, 16'hFFFF));
        dir_rows.push_back(row_byte(8'h3C, 1'b1));
        dir_rows.push_back(row_cfg(CFG_SYNC_PATTERN, SYNC_RESET));
        dir_rows.push_back(row_cfg(CFG_STUFF_LIMIT, 16'(STUFF_RESET)));

        foreach (dir_rows[n]) begin
            r = dir_rows[n];
            if (r.is_cfg) begin
                wait_idle();
                write_reg(r.idx, r.val);
            end else begin
                send_byte(r.item, r.typed_n, r.typed0, r.typed1);
            end
        end

        // Random packets, one configuration and flow-control mix per phase.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    write_reg(CFG_SYNC_PATTERN, 16'($urandom));
                    write_reg(CFG_STUFF_LIMIT, 16'd1);
                end
                1: begin
                    write_reg(CFG_SYNC_PATTERN, 16'hFFFF);
                    write_reg(CFG_STUFF_LIMIT, 16'd7);
                end
                2: begin
                    write_reg(CFG_SYNC_PATTERN, 16'h0000);
                    write_reg(CFG_STUFF_LIMIT, 16'd0);
                end
                default: begin
                    write_reg(CFG_SYNC_PATTERN, 16'($urandom));
                    write_reg(CFG_STUFF_LIMIT, 16'($urandom_range(7)));
                end
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            // Long receiver hold-off while bytes keep coming.
            if (p == 4) hold_reqs++;

            sent = 0;
            while (sent < PHASE_BYTES) begin
                len = $urandom_range(1, 12);
                for (int j = 0; j < len && sent < PHASE_BYTES; j++) begin
                    last = (j == len - 1) || (sent == PHASE_BYTES - 1);
                    it.data_byte = pick_byte();
                    it.last_byte = last;
                    send_byte(it, 0, '0, '0);
                    sent++;
                end
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== usb_nrzi_bitstuff_serializer_unit.f =====
design/usbnrzi_pkg.sv
design/usb_nrzi_bitstuff_serializer_unit.sv
tb/sv/tb_top.sv
